@@ rtl/h264_annexb_header_capture_top_defines.svh @@
// Assertion macros for the header capture block
`ifndef H264_ANNEXB_HEADER_CAPTURE_TOP_DEFINES_SVH
`define H264_ANNEXB_HEADER_CAPTURE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define AHC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ahc check failed");
`define AHC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ahc check failed");
`else
`define AHC_ASSERT_NOW(label, pre, post)
`define AHC_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ rtl/ahc_pkg.sv @@
`default_nettype none
package ahc_pkg;
    localparam int HDR_BYTES = 256;
    localparam int KF_BYTES = 65536;
    localparam int HDR_AW = $clog2(HDR_BYTES);
    localparam int KF_AW = $clog2(KF_BYTES);
    localparam int LEN_W = 17;
    localparam int CNT_LIMIT = ((HDR_BYTES > KF_BYTES) ? HDR_BYTES : KF_BYTES) + 4;
    localparam int CNT_W = $clog2(CNT_LIMIT + 1);
    localparam logic [3:0] MIN_LEN_RESET = 4'd5;
    localparam logic [3:0] NBUF_MAX = 4'd15;
    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;
    localparam logic [4:0] NAL_IDR = 5'd5;
    localparam logic [7:0] START_BYTE = 8'h01;

    typedef enum logic [1:0] {PH_SEARCH, PH_TYPE, PH_UNIT} phase_t;
    typedef enum logic [1:0] {ST_SPS = 2'd0, ST_PPS = 2'd1, ST_KEY = 2'd2, ST_NONE = 2'd3} store_t;

    typedef struct packed {
        logic              we;
        logic              is_kf;
        logic [HDR_AW+1:0] hdr_addr;
        logic [KF_AW:0]    kf_addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic              re;
        logic              is_kf;
        logic [HDR_AW+1:0] hdr_addr;
        logic [KF_AW:0]    kf_addr;
    } mem_rd_t;

    typedef struct packed {
        logic             kind;
        logic [1:0]       unit_kind;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             valid;
        logic             from_mem;
        logic [7:0]       cbyte;
    } res_t;

    function automatic logic [CNT_W-1:0] cap_of(input store_t s);
        cap_of = (s == ST_KEY) ? CNT_W'(KF_BYTES) : CNT_W'(HDR_BYTES);
    endfunction

    function automatic store_t store_of(input logic [4:0] t);
        case (t)
            NAL_SPS: store_of = ST_SPS;
            NAL_PPS: store_of = ST_PPS;
            NAL_IDR: store_of = ST_KEY;
            default: store_of = ST_NONE;
        endcase
    endfunction
endpackage
`default_nettype wire

@@ rtl/ahc_store.sv @@
`default_nettype none
module ahc_store import ahc_pkg::*; (
    input  wire logic    clk,
    input  wire mem_wr_t wr,
    input  wire mem_rd_t rd,
    output logic [7:0]   rdata
);
    logic [7:0] hdr_mem [0:4*HDR_BYTES-1];
    logic [7:0] kf_mem [0:2*KF_BYTES-1];
    logic [7:0] hdr_rd_reg;
    logic [7:0] kf_rd_reg;
    logic       is_kf_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we && !wr.is_kf)
        begin
            hdr_mem[wr.hdr_addr] <= wr.data;
        end
        if (rd.re)
        begin
            hdr_rd_reg <= hdr_mem[rd.hdr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we && wr.is_kf)
        begin
            kf_mem[wr.kf_addr] <= wr.data;
        end
        if (rd.re)
        begin
            kf_rd_reg <= kf_mem[rd.kf_addr];
            is_kf_reg <= rd.is_kf;
        end
    end

    assign rdata = is_kf_reg ? kf_rd_reg : hdr_rd_reg;
endmodule
`default_nettype wire

@@ rtl/ahc_scan.sv @@
`default_nettype none
module ahc_scan import ahc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        accept,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_of_buffer,
    input  wire logic [1:0]  store_select,
    input  wire logic [15:0] read_index,
    output mem_wr_t          wr,
    output mem_rd_t          rd,
    output res_t             res,
    output logic             res_valid
);
    logic [2:0][7:0]       recent_reg, recent_next;
    phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [3:0]            nbuf_reg, nbuf_next;
    logic                  code4_reg, code4_next;
    store_t                cur_reg, cur_next;
    logic [2:0]            held_reg, held_next;
    logic [2:0][CNT_W-1:0] held_len_reg, held_len_next;
    logic [2:0][CNT_W-1:0] clen_reg, clen_next;
    logic [2:0]            bank_reg, bank_next;
    logic [2:0][1:0]       flag_reg, flag_next;
    logic [3:0]            min_len_reg, min_len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg   <= '0;
            phase_reg    <= PH_SEARCH;
            count_reg    <= '0;
            nbuf_reg     <= '0;
            code4_reg    <= 1'b0;
            cur_reg      <= ST_NONE;
            held_reg     <= '0;
            held_len_reg <= '0;
            clen_reg     <= '0;
            bank_reg     <= '0;
            flag_reg     <= '0;
            min_len_reg  <= MIN_LEN_RESET;
        end
        else
        begin
            recent_reg   <= recent_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            nbuf_reg     <= nbuf_next;
            code4_reg    <= code4_next;
            cur_reg      <= cur_next;
            held_reg     <= held_next;
            held_len_reg <= held_len_next;
            clen_reg     <= clen_next;
            bank_reg     <= bank_next;
            flag_reg     <= flag_next;
            min_len_reg  <= min_len_next;
        end
    end

    always_comb
    begin
        logic [3:0]       nbuf;
        logic             enough;
        logic [2:0]       bank_mid;
        logic             hit;
        logic             four;
        logic             end_en;
        logic [CNT_W-1:0] end_len;
        logic [CNT_W-1:0] sub;
        store_t           end_st;
        store_t           s_new;
        logic             rd_code4;
        logic [15:0]      one_pos;
        logic [CNT_W-1:0] widx;
        store_t           wst;
        logic             wen;

        recent_next   = recent_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        nbuf_next     = nbuf_reg;
        code4_next    = code4_reg;
        cur_next      = cur_reg;
        held_next     = held_reg;
        held_len_next = held_len_reg;
        clen_next     = clen_reg;
        bank_next     = bank_reg;
        flag_next     = flag_reg;
        min_len_next  = cfg_wen ? cfg_wdata : min_len_reg;
        wr            = '0;
        rd            = '0;
        res           = '0;
        res_valid     = 1'b0;
        nbuf          = '0;
        enough        = 1'b0;
        bank_mid      = bank_reg;
        hit           = 1'b0;
        four          = 1'b0;
        end_en        = 1'b0;
        end_len       = '0;
        sub           = '0;
        end_st        = ST_NONE;
        s_new         = ST_NONE;
        rd_code4      = 1'b0;
        one_pos       = '0;
        widx          = '0;
        wst           = ST_NONE;
        wen           = 1'b0;

        if (accept && mode)
        begin
            res.kind  = 1'b1;
            res_valid = 1'b1;
            rd.re     = 1'b1;
            if (store_select != ST_NONE)
            begin
                res.unit_kind = store_select;
                res.len       = LEN_W'(clen_reg[store_select]);
                res.valid     = 32'(read_index) < 32'(clen_reg[store_select]);
                rd.is_kf      = (store_select == ST_KEY);
                rd.hdr_addr   = {store_select[0], bank_reg[store_select],
                                 read_index[HDR_AW-1:0]};
                rd.kf_addr    = {bank_reg[ST_KEY], KF_AW'(read_index)};
                rd_code4      = flag_reg[store_select][bank_reg[store_select]];
                one_pos       = rd_code4 ? 16'd3 : 16'd2;
                if (read_index < one_pos)
                begin
                    res.cbyte = 8'h00;
                end
                else if (read_index == one_pos)
                begin
                    res.cbyte = START_BYTE;
                end
                else
                begin
                    res.from_mem = 1'b1;
                end
                if (!res.valid)
                begin
                    res.from_mem = 1'b0;
                    res.cbyte    = 8'h00;
                end
            end
        end
        else if (accept)
        begin
            nbuf      = (nbuf_reg < NBUF_MAX) ? nbuf_reg + 4'd1 : NBUF_MAX;
            nbuf_next = nbuf;
            enough    = (nbuf >= min_len_reg);

            // commit units held back by a short buffer
            if (enough)
            begin
                for (int s = 0; s < 3; s++)
                begin
                    if (held_reg[s])
                    begin
                        bank_mid[s] = ~bank_mid[s];
                        clen_next[s] = held_len_reg[s];
                    end
                end
                held_next = '0;
            end

            hit  = (data_byte == START_BYTE) && (nbuf_reg >= 4'd2)
                   && (recent_reg[0] == 8'h00) && (recent_reg[1] == 8'h00);
            four = hit && (nbuf_reg >= 4'd3) && (recent_reg[2] == 8'h00);

            if (hit)
            begin
                if (phase_reg == PH_UNIT)
                begin
                    sub     = four ? CNT_W'(3) : CNT_W'(2);
                    end_en  = 1'b1;
                    end_st  = cur_reg;
                    end_len = (count_reg >= sub) ? count_reg - sub : '0;
                end
                phase_next = PH_TYPE;
                code4_next = four;
                count_next = '0;
            end
            else if (phase_reg == PH_TYPE)
            begin
                s_new = store_of(data_byte[4:0] & NAL_TYPE_MASK);
                if (s_new != ST_NONE)
                begin
                    held_next[s_new] = 1'b0;
                    flag_next[s_new][~bank_mid[s_new]] = code4_reg;
                end
                wst        = s_new;
                wen        = (s_new != ST_NONE);
                widx       = code4_reg ? CNT_W'(4) : CNT_W'(3);
                cur_next   = s_new;
                count_next = code4_reg ? CNT_W'(5) : CNT_W'(4);
                phase_next = PH_UNIT;
            end
            else if (phase_reg == PH_UNIT)
            begin
                wst  = cur_reg;
                wen  = (cur_reg != ST_NONE) && (count_reg < cap_of(cur_reg));
                widx = count_reg;
                if (count_reg < CNT_W'(CNT_LIMIT))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end

            if (wen)
            begin
                wr.we       = 1'b1;
                wr.is_kf    = (wst == ST_KEY);
                wr.data     = data_byte;
                wr.hdr_addr = {wst[0], ~bank_mid[wst], widx[HDR_AW-1:0]};
                wr.kf_addr  = {~bank_mid[ST_KEY], widx[KF_AW-1:0]};
            end

            recent_next = {recent_reg[1], recent_reg[0], data_byte};

            if (last_of_buffer && (phase_next == PH_UNIT))
            begin
                end_en  = 1'b1;
                end_st  = cur_next;
                end_len = count_next;
            end

            if (end_en)
            begin
                cur_next = ST_NONE;
                if (end_st != ST_NONE)
                begin
                    if (end_len > cap_of(end_st))
                    begin
                        if (enough)
                        begin
                            res_valid     = 1'b1;
                            res.unit_kind = end_st;
                            res.len       = LEN_W'(cap_of(end_st) + CNT_W'(1));
                            res.ovf       = 1'b1;
                        end
                    end
                    else if (!enough)
                    begin
                        held_next[end_st]     = 1'b1;
                        held_len_next[end_st] = end_len;
                    end
                    else
                    begin
                        bank_mid[end_st]  = ~bank_mid[end_st];
                        clen_next[end_st] = end_len;
                        res_valid         = 1'b1;
                        res.unit_kind     = end_st;
                        res.len           = LEN_W'(end_len);
                    end
                end
            end
            bank_next = bank_mid;

            if (last_of_buffer)
            begin
                recent_next = '0;
                phase_next  = PH_SEARCH;
                count_next  = '0;
                nbuf_next   = '0;
                code4_next  = 1'b0;
                cur_next    = ST_NONE;
                held_next   = '0;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/h264_annexb_header_capture_top.sv @@
// H.264 Annex B header capture.
// Input stream: one transfer per byte. tuser is the mode (0 stream byte, 1 store
// read), tlast marks the final byte of a buffer. Stream bytes are scanned for
// start codes; sequence, picture parameter and keyframe units are written into
// double-banked memories and made current when a unit ends in a buffer that
// has reached the minimum length. Output stream: one transfer per read and per
// captured unit ending once the buffer has the minimum length. Throughput is
// one input transfer per cycle while the output is not stalled, set by the
// single write port (stream) or single read port (read mode) of the unit
// memories. Results pass the registered memory read, then the output register.
// Configuration: cfg_wen with cfg_wdata sets the minimum buffer length
// (reset 5); write it only while the block is idle.
// Reset clears the scan state, committed lengths and bank selects; no memory
// clearing pass is made. When the receiver stalls, the output register and one
// result stage fill, then s_axis_tready drops until the output is taken.
`default_nettype none
`include "h264_annexb_header_capture_top_defines.svh"
module h264_annexb_header_capture_top import ahc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // data_byte[7:0], store_select[9:8], read_index[25:10]
    input  wire logic [31:0] s_axis_tdata,
    // mode
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // unit_kind[1:0], unit_length[18:2], overflowed[19], read_byte[27:20],
    // read_valid[28]
    output logic [31:0]      m_axis_tdata,
    // result_kind
    output logic             m_axis_tuser
);
    mem_wr_t     wr;
    mem_rd_t     rd;
    res_t        res;
    logic        res_valid;
    logic [7:0]  rdata;
    logic        accept;
    logic        s1_move;
    logic        s1_valid_reg, s1_valid_next;
    res_t        s1_res_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic        out_user_reg;
    logic [7:0]  s1_byte;

    assign s1_move       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ahc_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .accept         (accept),
        .mode           (s_axis_tuser),
        .data_byte      (s_axis_tdata[7:0]),
        .last_of_buffer (s_axis_tlast),
        .store_select   (s_axis_tdata[9:8]),
        .read_index     (s_axis_tdata[25:10]),
        .wr             (wr),
        .rd             (rd),
        .res            (res),
        .res_valid      (res_valid)
    );

    ahc_store u_store (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = res_valid;
        end
    end

    assign s1_byte = s1_res_reg.from_mem ? rdata : s1_res_reg.cbyte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_move && s1_valid_reg)
        begin
            out_user_reg <= s1_res_reg.kind;
            out_data_reg <= {3'b000, s1_res_reg.valid, s1_byte, s1_res_reg.ovf,
                             s1_res_reg.len, s1_res_reg.unit_kind};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `AHC_ASSERT_NOW(a_ready_when_free, !s1_valid_reg, s_axis_tready)
    `AHC_ASSERT_NOW(a_ovf_not_read, m_axis_tvalid && m_axis_tdata[19], !m_axis_tuser && !m_axis_tdata[28])
    `AHC_ASSERT_NOW(a_bad_read_zero, m_axis_tvalid && m_axis_tuser && !m_axis_tdata[28], m_axis_tdata[27:20] == 8'h00)
    `AHC_ASSERT_NEXT(a_read_reaches_s1, accept && s_axis_tuser, s1_valid_reg)
endmodule
`default_nettype wire
